### src/otcg_pkg.sv
// Package for the OLED text cursor command generator.
// Holds the font geometry, the opcode and character codes, and the step layout
// of one printed glyph. No dependencies.
package otcg_pkg;

  // Font store geometry.
  localparam int GLYPH_COUNT  = 96;
  localparam int GLYPH_W      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int SMALL_COLS   = 6;
  localparam int LARGE_BYTES  = 16;
  localparam int SMALL_DEPTH  = GLYPH_COUNT * SMALL_COLS;
  localparam int LARGE_DEPTH  = GLYPH_COUNT * LARGE_BYTES;
  localparam int SMALL_AW     = $clog2(SMALL_DEPTH);
  localparam int LARGE_AW     = $clog2(LARGE_DEPTH);

  // Stream field widths.
  localparam int IN_TDATA_W   = 24;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 8;

  typedef enum logic [1:0] {
    OP_PUT        = 2'd0,
    OP_LOAD_SMALL = 2'd1,
    OP_LOAD_LARGE = 2'd2,
    OP_HOME       = 2'd3
  } opcode_e;

  // Character codes.
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] FIRST_CODE = 8'd32;

  // Cursor geometry.
  localparam logic [7:0] WRAP_X         = 8'd120;
  localparam logic [7:0] TAB_SMALL      = 8'd24;
  localparam logic [7:0] TAB_LARGE      = 8'd32;
  localparam logic [7:0] ADV_SMALL      = 8'd6;
  localparam logic [7:0] ADV_LARGE      = 8'd8;
  localparam logic [3:0] MAX_PAGE_SMALL = 4'd7;
  localparam logic [3:0] MAX_PAGE_LARGE = 4'd6;

  // Display controller command bytes.
  localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
  localparam logic [7:0] CMD_PAGE_TOP   = 8'd7;
  localparam logic [7:0] CMD_COL_HI     = 8'h10;
  localparam logic [7:0] NIBBLE_LO_MASK = 8'h0F;
  localparam logic [7:0] NIBBLE_HI_MASK = 8'hF0;

  // Output step layout of one glyph.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_FIRST_DATA = 5'd3;
  localparam logic [STEP_W-1:0] STEP_LAST_SMALL = 5'd8;
  localparam logic [STEP_W-1:0] STEP_UPPER_LAST = 5'd10;
  localparam logic [STEP_W-1:0] STEP_TRIPLE2    = 5'd11;
  localparam logic [STEP_W-1:0] STEP_LOWER_DATA = 5'd14;
  localparam logic [STEP_W-1:0] STEP_LAST_LARGE = 5'd21;
  localparam logic [STEP_W-1:0] STEP_LOWER_SKEW = 5'd6;

  // Position of a byte inside a command triple.
  localparam logic [1:0] TRIPLE_PAGE = 2'd0;
  localparam logic [1:0] TRIPLE_LO   = 2'd1;
  localparam logic [1:0] TRIPLE_HI   = 2'd2;

endpackage

### src/oled_text_cursor_command_gen.sv
// Top level of the OLED text cursor command generator: cursor, glyph stores and
// the byte sequencer for page-mode character output.
// Depends on otcg_pkg.
//
//  channel   | dir | handshake                  | payload (low bit first)
//  ----------+-----+----------------------------+-------------------------------------------
//  s_axis    | in  | s_axis_tvalid_i/tready_o   | tuser: opcode; tdata: char_code,
//            |     |                            |   glyph_column, glyph_byte, zero pad
//  m_axis    | out | m_axis_tvalid_o/tready_i   | tdata: out_byte; tuser: is_data;
//            |     |                            |   tlast: last
//  cfg       | in  | cfg_we_i                   | cfg_wdata_i: font_mode
//
// A request that loads a glyph byte, homes the cursor, or moves it (CR, LF, TAB,
// stopped or unprintable characters) produces no output bytes. A printable character
// produces 9 bytes in 6x8 mode and 22 bytes in 8x16 mode. The byte sequencer walks
// one step counter and one shared address adder through the glyph store, one read
// port per store, one byte a cycle while the output does not stall.
// Output backpressure holds the sequencer; the output register lets a finished
// byte wait while the next request is taken. Reset clears the cursor, the stop
// flag and the font mode; the glyph stores hold no reset and need no clearing.
module oled_text_cursor_command_gen (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: font_mode.
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i,
  // Requests. tuser: opcode[1:0].
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: char_code[7:0], glyph_column[11:8], glyph_byte[19:12], zeros[23:20].
  input  logic [otcg_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic [otcg_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  // Results. tdata: out_byte[7:0]; tuser: is_data; tlast: last.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [otcg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);
  import otcg_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  // Request fields.
  opcode_e      in_op;
  logic [7:0]   in_char;
  logic [3:0]   in_col;
  logic [7:0]   in_byte;
  logic         accept;

  assign in_op   = opcode_e'(s_axis_tuser_i);
  assign in_char = s_axis_tdata_i[7:0];
  assign in_col  = s_axis_tdata_i[11:8];
  assign in_byte = s_axis_tdata_i[19:12];
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;

  // State registers.
  logic                 state_q, state_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [7:0]           cursor_x_q, cursor_x_d;
  logic [3:0]           cursor_page_q, cursor_page_d;
  logic                 stop_flag_q, stop_flag_d;
  logic                 font_mode_q;
  // Latched position and glyph base for the character being printed.
  logic [7:0]           pos_x_q, pos_x_d;
  logic [3:0]           pos_page_q, pos_page_d;
  logic [LARGE_AW-1:0]  base_q, base_d;
  logic                 large_q, large_d;

  // Glyph lookup for the incoming character.
  logic [7:0]           ch_off;
  logic                 glyph_ok;
  logic [LARGE_AW-1:0]  g_ext;
  logic [LARGE_AW-1:0]  small_base_g;
  logic [LARGE_AW-1:0]  large_base_g;

  assign ch_off       = in_char - FIRST_CODE;
  assign glyph_ok     = (in_char >= FIRST_CODE) && (ch_off < 8'(GLYPH_COUNT));
  assign g_ext        = LARGE_AW'(ch_off[GLYPH_W-1:0]);
  assign small_base_g = (g_ext << 2) + (g_ext << 1);
  assign large_base_g = g_ext << 4;

  // Cursor update for a put request: wrap test, stop test, then the character.
  logic        mode_large;
  logic [3:0]  pg_step;
  logic        wrap;
  logic [7:0]  x1;
  logic [3:0]  page1;
  logic        over;
  logic [3:0]  page2;
  logic        stop2;
  logic [7:0]  put_x;
  logic [3:0]  put_page;
  logic        emit_go;

  always_comb begin
    mode_large = font_mode_q;
    pg_step = mode_large ? 4'd2 : 4'd1;
    wrap    = cursor_x_q > WRAP_X;
    x1      = wrap ? 8'd0 : cursor_x_q;
    page1   = wrap ? cursor_page_q + pg_step : cursor_page_q;
    over    = page1 > (mode_large ? MAX_PAGE_LARGE : MAX_PAGE_SMALL);
    page2   = over ? 4'd0 : page1;
    stop2   = stop_flag_q || over;
    put_x    = x1;
    put_page = page2;
    emit_go  = 1'b0;
    if (!stop2) begin
      if (in_char == CH_CR) begin
        put_x = 8'd0;
      end else if (in_char == CH_LF) begin
        put_page = page2 + pg_step;
      end else if (in_char == CH_TAB) begin
        put_x = x1 + (mode_large ? TAB_LARGE : TAB_SMALL);
      end else if (glyph_ok) begin
        put_x   = x1 + (mode_large ? ADV_LARGE : ADV_SMALL);
        emit_go = 1'b1;
      end
    end
  end

  // Sequencer step decode.
  logic                 adv;
  logic [STEP_W-1:0]    step_nxt;
  logic                 cur_last;
  logic                 next_data;
  logic [STEP_W-1:0]    next_idx;
  logic                 out_valid_q;

  assign adv      = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i);
  assign step_nxt = step_q + 5'd1;
  assign cur_last = step_q == (large_q ? STEP_LAST_LARGE : STEP_LAST_SMALL);

  always_comb begin
    if (large_q) begin
      next_data = (step_nxt inside {[STEP_FIRST_DATA:STEP_UPPER_LAST]}) ||
                  (step_nxt inside {[STEP_LOWER_DATA:STEP_LAST_LARGE]});
      next_idx  = (step_nxt >= STEP_TRIPLE2) ? step_nxt - STEP_LOWER_SKEW
                                             : step_nxt - STEP_FIRST_DATA;
    end else begin
      next_data = step_nxt inside {[STEP_FIRST_DATA:STEP_LAST_SMALL]};
      next_idx  = step_nxt - STEP_FIRST_DATA;
    end
  end

  // Shared address adder: store writes while idle, glyph reads while printing.
  logic [LARGE_AW-1:0]  addr_base;
  logic [3:0]           addr_idx;
  logic [LARGE_AW-1:0]  addr;

  always_comb begin
    if (state_q == S_IDLE) begin
      addr_base = (in_op == OP_LOAD_SMALL) ? small_base_g : large_base_g;
      addr_idx  = in_col;
    end else begin
      addr_base = base_q;
      addr_idx  = next_idx[3:0];
    end
  end
  assign addr = addr_base + LARGE_AW'(addr_idx);

  // Glyph stores.
  logic [7:0] small_mem [SMALL_DEPTH];
  logic [7:0] large_mem [LARGE_DEPTH];
  logic [7:0] small_rd_q;
  logic [7:0] large_rd_q;
  logic       small_we, large_we, small_re, large_re;

  assign small_we = accept && (in_op == OP_LOAD_SMALL) && glyph_ok &&
                    (in_col < 4'(SMALL_COLS));
  assign large_we = accept && (in_op == OP_LOAD_LARGE) && glyph_ok;
  assign small_re = adv && next_data && !large_q;
  assign large_re = adv && next_data && large_q;

  always_ff @(posedge clk_i) begin
    if (small_we) begin
      small_mem[addr[SMALL_AW-1:0]] <= in_byte;
    end
    if (small_re) begin
      small_rd_q <= small_mem[addr[SMALL_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (large_we) begin
      large_mem[addr] <= in_byte;
    end
    if (large_re) begin
      large_rd_q <= large_mem[addr];
    end
  end

  // Request handling and sequencer control.
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    cursor_x_d    = cursor_x_q;
    cursor_page_d = cursor_page_q;
    stop_flag_d   = stop_flag_q;
    pos_x_d       = pos_x_q;
    pos_page_d    = pos_page_q;
    base_d        = base_q;
    large_d       = large_q;
    if (state_q == S_IDLE) begin
      if (accept) begin
        case (in_op)
          OP_PUT: begin
            cursor_x_d    = put_x;
            cursor_page_d = put_page;
            stop_flag_d   = stop2;
            if (emit_go) begin
              state_d    = S_EMIT;
              step_d     = '0;
              pos_x_d    = x1;
              pos_page_d = page2;
              base_d     = mode_large ? large_base_g : small_base_g;
              large_d    = mode_large;
            end
          end
          OP_HOME: begin
            cursor_x_d    = '0;
            cursor_page_d = '0;
            stop_flag_d   = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end else if (adv) begin
      if (cur_last) begin
        state_d = S_IDLE;
      end else begin
        step_d = step_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      step_q        <= '0;
      cursor_x_q    <= '0;
      cursor_page_q <= '0;
      stop_flag_q   <= 1'b0;
      font_mode_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      step_q        <= step_d;
      cursor_x_q    <= cursor_x_d;
      cursor_page_q <= cursor_page_d;
      stop_flag_q   <= stop_flag_d;
      if (cfg_we_i) begin
        font_mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q    <= pos_x_d;
    pos_page_q <= pos_page_d;
    base_q     <= base_d;
    large_q    <= large_d;
  end

  // Byte for the current step: a command of a position triple or a glyph byte.
  logic              in_triple2;
  logic              is_cmd;
  logic [STEP_W-1:0] tri_step;
  logic [3:0]        cmd_page;
  logic [7:0]        cmd_byte;
  logic [7:0]        cur_byte;

  always_comb begin
    in_triple2 = large_q && (step_q inside {[STEP_TRIPLE2:STEP_LOWER_DATA - 5'd1]});
    is_cmd     = (step_q < STEP_FIRST_DATA) || in_triple2;
    tri_step   = in_triple2 ? step_q - STEP_TRIPLE2 : step_q;
    cmd_page   = in_triple2 ? pos_page_q + 4'd1 : pos_page_q;
    case (tri_step[1:0])
      TRIPLE_PAGE: cmd_byte = CMD_PAGE_BASE + CMD_PAGE_TOP - {5'd0, cmd_page[2:0]};
      TRIPLE_LO:   cmd_byte = pos_x_q & NIBBLE_LO_MASK;
      TRIPLE_HI:   cmd_byte = ((pos_x_q & NIBBLE_HI_MASK) >> 4) | CMD_COL_HI;
      default:     cmd_byte = ((pos_x_q & NIBBLE_HI_MASK) >> 4) | CMD_COL_HI;
    endcase
    if (is_cmd) begin
      cur_byte = cmd_byte;
    end else begin
      cur_byte = large_q ? large_rd_q : small_rd_q;
    end
  end

  // Output register.
  logic [7:0] out_byte_q;
  logic       out_data_q;
  logic       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= cur_byte;
      out_data_q <= !is_cmd;
      out_last_q <= cur_last;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // A command byte never closes a character.
  a_cmd_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> !m_axis_tlast_o)
    else $error("command byte marked as last");

  // A stopped cursor never starts printing.
  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_op == OP_PUT) && stop_flag_q |=> state_q == S_IDLE)
    else $error("printing started while stopped");

  // The step counter stays inside the glyph layout.
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> step_q <= (large_q ? STEP_LAST_LARGE : STEP_LAST_SMALL))
    else $error("step counter beyond last byte");

  // The last byte hands control back to request intake.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && cur_last |=> s_axis_tready_o)
    else $error("sequencer did not return to idle after last byte");

endmodule
